[rtl/bfsp_pkg.sv]
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types and constants of the shortest-path engine.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int unsigned MaxVertices = 256;
  localparam int unsigned MaxEdges    = 4096;
  localparam int unsigned WeightBits  = 16;
  localparam int unsigned VertBits    = $clog2(MaxVertices);
  localparam int unsigned CountBits   = $clog2(MaxVertices + 1);
  localparam int unsigned EdgeBits    = $clog2(MaxEdges);
  localparam int unsigned TotalBits   = $clog2(MaxEdges + 1);
  localparam logic [WeightBits-1:0] InfDist = '1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CYCLE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RUN_INIT,
    S_PASS_START,
    S_SCAN,
    S_DIST_RD,
    S_RELAX,
    S_PASS_END,
    S_FINISH,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic load;        // latch input transaction
    logic exec_clear;
    logic exec_add;
    logic run_reject;
    logic run_init;
    logic pass_start;
    logic edge_rd;
    logic dist_rd;
    logic relax;
    logic pass_end;
    logic run_done;
    logic read_issue;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic start_oor;
    logic scan_end;
    logic improve;
    logic final_pass;
    logic out_free;
  } stat_t;

endpackage

[rtl/bfsp_ctrl.sv]
// ----------------------------------------------------------------------------
// bfsp_ctrl
// Sequencer: decodes transactions and steps the relaxation passes.
// ----------------------------------------------------------------------------
module bfsp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bfsp_pkg::stat_t stat_i,
  output bfsp_pkg::cmd_t  cmd_o
);

  bfsp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfsp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bfsp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bfsp_pkg::S_DECODE;
        end
      end
      bfsp_pkg::S_DECODE: begin
        unique case (stat_i.op)
          bfsp_pkg::OP_CLEAR: begin
            cmd_o.exec_clear = 1'b1;
            state_d          = bfsp_pkg::S_RESULT;
          end
          bfsp_pkg::OP_ADD: begin
            cmd_o.exec_add = 1'b1;
            state_d        = bfsp_pkg::S_RESULT;
          end
          bfsp_pkg::OP_RUN: begin
            if (stat_i.start_oor) begin
              cmd_o.run_reject = 1'b1;
              state_d          = bfsp_pkg::S_RESULT;
            end else begin
              state_d = bfsp_pkg::S_RUN_INIT;
            end
          end
          default: begin
            cmd_o.read_issue = 1'b1;
            state_d          = bfsp_pkg::S_RESULT;
          end
        endcase
      end
      bfsp_pkg::S_RUN_INIT: begin
        cmd_o.run_init = 1'b1;
        state_d        = bfsp_pkg::S_PASS_START;
      end
      bfsp_pkg::S_PASS_START: begin
        cmd_o.pass_start = 1'b1;
        state_d          = bfsp_pkg::S_SCAN;
      end
      bfsp_pkg::S_SCAN: begin
        if (stat_i.scan_end) begin
          state_d = bfsp_pkg::S_PASS_END;
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d       = bfsp_pkg::S_DIST_RD;
        end
      end
      bfsp_pkg::S_DIST_RD: begin
        cmd_o.dist_rd = 1'b1;
        state_d       = bfsp_pkg::S_RELAX;
      end
      bfsp_pkg::S_RELAX: begin
        cmd_o.relax = 1'b1;
        // check pass stops at the first relaxable edge
        if (stat_i.final_pass && stat_i.improve) begin
          state_d = bfsp_pkg::S_FINISH;
        end else begin
          state_d = bfsp_pkg::S_SCAN;
        end
      end
      bfsp_pkg::S_PASS_END: begin
        if (stat_i.final_pass) begin
          state_d = bfsp_pkg::S_FINISH;
        end else begin
          cmd_o.pass_end = 1'b1;
          state_d        = bfsp_pkg::S_PASS_START;
        end
      end
      bfsp_pkg::S_FINISH: begin
        cmd_o.run_done = 1'b1;
        state_d        = bfsp_pkg::S_RESULT;
      end
      bfsp_pkg::S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = bfsp_pkg::S_IDLE;
        end
      end
      default: state_d = bfsp_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/bfsp_dp.sv]
// ----------------------------------------------------------------------------
// bfsp_dp
// Datapath: edge store, distance and predecessor tables, counters, result.
// ----------------------------------------------------------------------------
module bfsp_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bfsp_pkg::cmd_t  cmd_i,
  output bfsp_pkg::stat_t stat_o,
  input  logic [39:0]     in_data_i,
  input  logic [8:0]      vertex_count_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     out_data_o
);

  localparam int unsigned VB = bfsp_pkg::VertBits;
  localparam int unsigned WB = bfsp_pkg::WeightBits;
  localparam int unsigned CB = bfsp_pkg::CountBits;
  localparam int unsigned TB = bfsp_pkg::TotalBits;
  localparam int unsigned EB = bfsp_pkg::EdgeBits;

  // latched transaction
  bfsp_pkg::op_e  op_q;
  logic [VB-1:0]  va_q, vb_q;
  logic [WB-1:0]  w_q;

  // memories
  logic [2*VB+WB-1:0] edge_mem [bfsp_pkg::MaxEdges];
  logic [WB-1:0]      dist_mem [bfsp_pkg::MaxVertices];
  logic [VB:0]        pred_mem [bfsp_pkg::MaxVertices];
  logic [bfsp_pkg::MaxVertices-1:0] valid_q;

  logic [TB-1:0]      total_q, k_q;
  logic [CB-1:0]      pass_q;
  logic               final_q, changed_q, cycle_q;
  logic [1:0]         stat_q;

  logic [2*VB+WB-1:0] edge_q;
  logic [WB-1:0]      du_q, dv_q;
  logic               vu_q, vv_q;
  logic [VB:0]        prd_q;

  logic [31:0]        res_q;
  logic               res_valid_q;

  logic [CB-1:0]      nv;
  logic [VB-1:0]      eu, ev;
  logic [WB-1:0]      ew, du, dv;
  logic [WB:0]        sum;
  logic               improve, a_oor, full;
  logic [VB-1:0]      rd_addr;

  // clamp vertex count into 1..MaxVertices
  always_comb begin
    if (vertex_count_i == '0) begin
      nv = CB'(1);
    end else if (vertex_count_i > 9'(bfsp_pkg::MaxVertices)) begin
      nv = CB'(bfsp_pkg::MaxVertices);
    end else begin
      nv = vertex_count_i[CB-1:0];
    end
  end

  assign eu      = edge_q[VB-1:0];
  assign ev      = edge_q[2*VB-1:VB];
  assign ew      = edge_q[2*VB+WB-1:2*VB];
  assign du      = vu_q ? du_q : bfsp_pkg::InfDist;
  assign dv      = vv_q ? dv_q : bfsp_pkg::InfDist;
  assign sum     = {1'b0, du} + {1'b0, ew};
  assign improve = ({1'b0, eu} < nv) && ({1'b0, ev} < nv) &&
                   (du != bfsp_pkg::InfDist) && (sum < {1'b0, dv});
  assign a_oor   = !({1'b0, va_q} < nv);
  assign full    = (total_q == TB'(bfsp_pkg::MaxEdges));
  assign rd_addr = cmd_i.read_issue ? va_q : eu;

  assign stat_o.op         = op_q;
  assign stat_o.start_oor  = a_oor;
  assign stat_o.scan_end   = (k_q == total_q);
  assign stat_o.improve    = improve;
  assign stat_o.final_pass = final_q;
  assign stat_o.out_free   = !res_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= bfsp_pkg::op_e'(in_data_i[1:0]);
      va_q <= in_data_i[9:2];
      vb_q <= in_data_i[17:10];
      w_q  <= in_data_i[33:18];
    end
  end

  // edge store
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_add && !full) begin
      edge_mem[total_q[EB-1:0]] <= {w_q, vb_q, va_q};
    end
    if (cmd_i.edge_rd) begin
      edge_q <= edge_mem[k_q[EB-1:0]];
    end
  end

  // distance and predecessor tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.run_init) begin
      dist_mem[va_q] <= '0;
      pred_mem[va_q] <= '0;
    end else if (cmd_i.relax && improve && !final_q) begin
      dist_mem[ev] <= sum[WB-1:0];
      pred_mem[ev] <= {1'b1, eu};
    end
    if (cmd_i.dist_rd || cmd_i.read_issue) begin
      du_q  <= dist_mem[rd_addr];
      vu_q  <= valid_q[rd_addr];
      prd_q <= pred_mem[rd_addr];
    end
    if (cmd_i.dist_rd) begin
      dv_q <= dist_mem[ev];
      vv_q <= valid_q[ev];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      total_q     <= '0;
      k_q         <= '0;
      pass_q      <= '0;
      final_q     <= 1'b0;
      changed_q   <= 1'b0;
      cycle_q     <= 1'b0;
      stat_q      <= bfsp_pkg::ST_OK;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cmd_i.exec_clear) begin
        total_q <= '0;
        stat_q  <= bfsp_pkg::ST_OK;
      end
      if (cmd_i.exec_add) begin
        if (full) begin
          stat_q <= bfsp_pkg::ST_FULL;
        end else begin
          total_q <= total_q + TB'(1);
          stat_q  <= bfsp_pkg::ST_OK;
        end
      end
      if (cmd_i.run_reject) begin
        stat_q <= bfsp_pkg::ST_RANGE;
      end
      if (cmd_i.run_init) begin
        // only the start vertex holds a distance
        valid_q <= {{(bfsp_pkg::MaxVertices-1){1'b0}}, 1'b1} << va_q;
        pass_q  <= '0;
        final_q <= !(nv > CB'(1));
      end
      if (cmd_i.pass_start) begin
        k_q       <= '0;
        changed_q <= 1'b0;
      end
      if (cmd_i.relax) begin
        k_q <= k_q + TB'(1);
        if (improve) begin
          changed_q <= 1'b1;
          if (!final_q) begin
            valid_q[ev] <= 1'b1;
          end
        end
      end
      if (cmd_i.pass_end) begin
        if (changed_q && ({1'b0, pass_q} + (CB+1)'(2) < {1'b0, nv})) begin
          pass_q <= pass_q + CB'(1);
        end else begin
          final_q <= 1'b1;
        end
      end
      if (cmd_i.run_done) begin
        cycle_q <= changed_q;
        stat_q  <= changed_q ? bfsp_pkg::ST_CYCLE : bfsp_pkg::ST_OK;
      end
      if (cmd_i.read_issue) begin
        stat_q <= a_oor ? bfsp_pkg::ST_RANGE :
                  (cycle_q ? bfsp_pkg::ST_CYCLE : bfsp_pkg::ST_OK);
      end
      if (cmd_i.res_load) begin
        res_valid_q <= 1'b1;
        if (op_q == bfsp_pkg::OP_READ) begin
          if (stat_q == bfsp_pkg::ST_RANGE) begin
            res_q <= {5'd0, stat_q, 1'b0, 8'd0, bfsp_pkg::InfDist};
          end else begin
            res_q <= {5'd0, stat_q, vu_q & prd_q[VB],
                      (vu_q & prd_q[VB]) ? prd_q[VB-1:0] : 8'd0,
                      vu_q ? du_q : bfsp_pkg::InfDist};
          end
        end else begin
          res_q <= {5'd0, stat_q, 25'd0};
        end
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

[rtl/bellman_ford_shortest_path_top.sv]
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_top
// Single-source shortest paths over a loaded edge list.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one transaction per command: clear edges, add edge,
// run from a start vertex, or read one vertex's distance and predecessor.
// Output stream (m_axis): exactly one result transaction per command.
// APB port: register 0 at address 0 is vertex_count (9 bits).
// Clear, add and read go from acceptance through the decode and result
// states to a loaded result before the next command is taken; the edge store,
// distance and predecessor tables are single-port-write memories with registered reads.
// A run makes P passes over the E loaded edges (P at most vertex_count,
// including the final check pass): each edge costs an edge-store read, a
// dual distance read and a compare/write.
// Reset empties the edge list, marks all distances unreachable and clears
// the cycle flag; no clearing pass is needed (per-vertex valid bits).
// The result sits in an output register; while it is stalled the next
// command is still accepted and processed up to its own result.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0], vertex_a[9:2], vertex_b[17:10], edge_weight[33:18]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // distance[15:0], predecessor[23:16], has_predecessor[24], status[26:25]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bfsp_pkg::cmd_t  cmd;
  bfsp_pkg::stat_t stat;
  logic [8:0]      vcount_q;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {23'd0, vcount_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= 9'd1;
    end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
      vcount_q <= pwdata[8:0];
    end
  end

  bfsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfsp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_data_i      (s_axis_tdata),
    .vertex_count_i (vcount_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

[bench/bellman_ford_shortest_path_top_tb.sv]
// ----------------------------------------------------------------------------
// bellman_ford_shortest_path_top_tb
// Self-checking bench for the shortest-path engine: edge loads, runs and
// vertex reads are streamed in and every result is checked against an
// in-bench Bellman-Ford predictor, over several vertex counts and idle mixes.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_path_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned HoldCycles = 600;

  // lowest field last, matching the result tdata layout
  typedef struct packed {
    bfsp_pkg::status_e status;
    logic              hasp;
    logic [7:0]        pred;
    logic [15:0]       distance;
  } path_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bellman_ford_shortest_path_top u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  edge_src [bfsp_pkg::MaxEdges];
  logic [7:0]  edge_dst [bfsp_pkg::MaxEdges];
  logic [15:0] edge_wt  [bfsp_pkg::MaxEdges];
  int unsigned edge_cnt;
  logic [15:0] dist_tab [bfsp_pkg::MaxVertices];
  logic [7:0]  pred_tab [bfsp_pkg::MaxVertices];
  logic        pred_ok  [bfsp_pkg::MaxVertices];
  logic        neg_cycle;
  logic [8:0]  vcount_reg;

  logic [39:0] cmd_q [$];
  path_res_t   path_q [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          n_runs = 0, n_reads = 0, n_full = 0, n_range = 0, n_results = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cyc = 0;

  function automatic bit relax_sweep(int unsigned nv, bit apply);
    bit changed;
    logic [16:0] sum;
    changed = 0;
    for (int unsigned k = 0; k < edge_cnt; k++) begin
      if (edge_src[k] >= nv || edge_dst[k] >= nv) continue;
      if (dist_tab[edge_src[k]] == bfsp_pkg::InfDist) continue;
      sum = dist_tab[edge_src[k]] + edge_wt[k];
      if (sum < dist_tab[edge_dst[k]]) begin
        changed = 1;
        if (!apply) return 1;
        dist_tab[edge_dst[k]] = sum[15:0];
        pred_tab[edge_dst[k]] = edge_src[k];
        pred_ok[edge_dst[k]]  = 1'b1;
      end
    end
    return changed;
  endfunction

  function automatic void clear_paths();
    for (int i = 0; i < bfsp_pkg::MaxVertices; i++) begin
      dist_tab[i] = bfsp_pkg::InfDist;
      pred_tab[i] = '0;
      pred_ok[i]  = 1'b0;
    end
  endfunction

  function automatic path_res_t predict_path(logic [39:0] cmd);
    bfsp_pkg::op_e op;
    logic [7:0]    a, b;
    logic [15:0]   w;
    int unsigned   nv;
    path_res_t     r;
    op = bfsp_pkg::op_e'(cmd[1:0]);
    a  = cmd[9:2];
    b  = cmd[17:10];
    w  = cmd[33:18];
    nv = (vcount_reg == 0) ? 1 :
         (vcount_reg > bfsp_pkg::MaxVertices) ? bfsp_pkg::MaxVertices : 32'(vcount_reg);
    r  = '{distance: '0, pred: '0, hasp: 1'b0, status: bfsp_pkg::ST_OK};
    case (op)
      bfsp_pkg::OP_CLEAR: edge_cnt = 0;
      bfsp_pkg::OP_ADD: begin
        if (edge_cnt >= bfsp_pkg::MaxEdges) begin
          r.status = bfsp_pkg::ST_FULL;
        end else begin
          edge_src[edge_cnt] = a;
          edge_dst[edge_cnt] = b;
          edge_wt[edge_cnt]  = w;
          edge_cnt++;
        end
      end
      bfsp_pkg::OP_RUN: begin
        if (a >= nv) begin
          r.status = bfsp_pkg::ST_RANGE;
        end else begin
          clear_paths();
          dist_tab[a] = '0;
          for (int unsigned p = 0; p + 1 < nv; p++)
            if (!relax_sweep(nv, 1)) break;
          neg_cycle = relax_sweep(nv, 0);
          r.status  = neg_cycle ? bfsp_pkg::ST_CYCLE : bfsp_pkg::ST_OK;
        end
      end
      default: begin
        if (a >= nv) begin
          r.distance = bfsp_pkg::InfDist;
          r.status   = bfsp_pkg::ST_RANGE;
        end else begin
          r.distance = dist_tab[a];
          r.pred     = pred_ok[a] ? pred_tab[a] : 8'd0;
          r.hasp     = pred_ok[a];
          r.status   = neg_cycle ? bfsp_pkg::ST_CYCLE : bfsp_pkg::ST_OK;
        end
      end
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      path_q.push_back(predict_path(s_axis_tdata));
      if (s_axis_tdata[1:0] == bfsp_pkg::OP_RUN) n_runs++;
      if (s_axis_tdata[1:0] == bfsp_pkg::OP_READ) n_reads++;
    end
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmd_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_go) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk_i) begin
    path_res_t exp_r, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[26:0];
      n_results++;
      if (got.status == bfsp_pkg::ST_FULL) n_full++;
      if (got.status == bfsp_pkg::ST_RANGE) n_range++;
      if (path_q.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        errors++;
      end else begin
        exp_r = path_q.pop_front();
        if (got.distance !== exp_r.distance) begin
          $error("distance: expected %0d, actual %0d", exp_r.distance, got.distance);
          errors++;
        end
        if (got.pred !== exp_r.pred) begin
          $error("predecessor: expected %0d, actual %0d", exp_r.pred, got.pred);
          errors++;
        end
        if (got.hasp !== exp_r.hasp) begin
          $error("has_predecessor: expected %0b, actual %0b", exp_r.hasp, got.hasp);
          errors++;
        end
        if (got.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, got.status);
          errors++;
        end
      end
    end
    m_axis_tready <= rst_ni && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("timeout with %0d results outstanding", path_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [39:0] pack_cmd(bfsp_pkg::op_e op, logic [7:0] a, logic [7:0] b,
                                           logic [15:0] w);
    return {6'b0, w, b, a, op};
  endfunction

  task automatic send(bfsp_pkg::op_e op, int unsigned a, int unsigned b, int unsigned w);
    cmd_q.push_back(pack_cmd(op, a[7:0], b[7:0], w[15:0]));
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || s_axis_tvalid || path_q.size() != 0 || hold_left != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_vcount(logic [8:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= {23'b0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    vcount_reg = val;
  endtask

  function automatic int unsigned rand_weight();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 'hFFFF;
      2:       return $urandom_range(65535);
      3:       return $urandom_range(65535, 32768);
      default: return $urandom_range(200);
    endcase
  endfunction

  // clear, load a small graph grouped by source, run, then query vertices
  task automatic graph_batch(int unsigned span, output int unsigned n);
    int unsigned ne, src;
    ne  = $urandom_range(24, 1);
    src = 0;
    n   = 0;
    send(bfsp_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
    n++;
    for (int unsigned i = 0; i < ne; i++) begin
      if ($urandom_range(3) == 0) src = $urandom_range(span);
      send(bfsp_pkg::OP_ADD, (src > 255) ? 255 : src,
           $urandom_range(7) == 0 ? $urandom : $urandom_range(span - 1),
           rand_weight());
      n++;
    end
    send(bfsp_pkg::OP_RUN, $urandom_range(9) == 0 ? $urandom : $urandom_range(span - 1),
         $urandom, $urandom);
    n++;
    for (int unsigned i = $urandom_range(12, 2); i > 0; i--) begin
      send(bfsp_pkg::OP_READ, $urandom_range(5) == 0 ? $urandom : $urandom_range(span),
           $urandom, $urandom);
      n++;
    end
    if ($urandom_range(3) == 0) begin
      // noise: a stray read, an appended edge and a run from vertex 255 (out of range below 256 vertices)
      send(bfsp_pkg::OP_READ, $urandom, $urandom, $urandom);
      send(bfsp_pkg::OP_ADD, $urandom, $urandom, $urandom);
      send(bfsp_pkg::OP_RUN, 255, $urandom, $urandom);
      n += 3;
    end
  endtask

  task automatic random_phase(logic [8:0] vc, int idle, int stall, int items);
    int unsigned span, n;
    set_vcount(vc);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    span = (vc == 0) ? 1 : (vc > 16) ? 16 : 32'(vc);
    while (items > 0) begin
      graph_batch(span, n);
      items -= n;
    end
    drain();
  endtask

  initial begin
    edge_cnt   = 0;
    neg_cycle  = 1'b0;
    vcount_reg = 9'd1;
    clear_paths();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, extremes, range checks
    send(bfsp_pkg::OP_READ, 0, 0, 0);
    send(bfsp_pkg::OP_READ, 255, 255, 'hFFFF);
    send(bfsp_pkg::OP_ADD, 0, 0, 0);
    send(bfsp_pkg::OP_RUN, 0, 0, 0);
    send(bfsp_pkg::OP_RUN, 1, 0, 0);
    send(bfsp_pkg::OP_READ, 0, 0, 0);
    drain();
    set_vcount(9'd511);
    send(bfsp_pkg::OP_CLEAR, 255, 255, 'hFFFF);
    send(bfsp_pkg::OP_ADD, 0, 255, 'hFFFE);
    send(bfsp_pkg::OP_ADD, 255, 1, 'hFFFF);
    send(bfsp_pkg::OP_ADD, 0, 1, 0);
    send(bfsp_pkg::OP_ADD, 1, 255, 1);
    send(bfsp_pkg::OP_RUN, 0, 0, 0);
    send(bfsp_pkg::OP_READ, 255, 0, 0);
    send(bfsp_pkg::OP_READ, 1, 0, 0);
    send(bfsp_pkg::OP_READ, 2, 0, 0);
    send(bfsp_pkg::OP_RUN, 255, 0, 0);
    send(bfsp_pkg::OP_READ, 0, 0, 0);
    drain();
    set_vcount(9'd0);
    send(bfsp_pkg::OP_READ, 0, 0, 0);
    send(bfsp_pkg::OP_READ, 1, 0, 0);
    send(bfsp_pkg::OP_RUN, 0, 0, 0);
    drain();

    // fill the edge store past its end, then empty it
    set_vcount(9'd2);
    send(bfsp_pkg::OP_CLEAR, 0, 0, 0);
    for (int i = 0; i <= bfsp_pkg::MaxEdges; i++)
      send(bfsp_pkg::OP_ADD, $urandom, $urandom, $urandom);
    send(bfsp_pkg::OP_ADD, 0, 1, 5);
    send(bfsp_pkg::OP_CLEAR, 0, 0, 0);
    drain();

    random_phase(9'd8,   0,  0,  220);
    random_phase(9'd16,  52, 0,  220);
    random_phase(9'd5,   0,  52, 220);
    random_phase(9'd256, 11, 11, 220);

    // receiver holds off while the sender keeps offering
    set_vcount(9'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 60; i++)
      send(bfsp_pkg::OP_READ, $urandom_range(3), $urandom, $urandom);
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    drain();

    random_phase(9'd1,   0,  52, 110);
    random_phase(9'd2,   52, 52, 110);
    random_phase(9'd200, 0,  0,  110);
    random_phase(9'd511, 11, 11, 110);

    repeat (40) @(posedge clk_i);
    $display("covered %0d results: %0d runs, %0d reads, %0d store-full, %0d out-of-range",
             n_results, n_runs, n_reads, n_full, n_range);
    if (errors == 0 && path_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
